[rtl/core/lrp_pkg.sv]
// Shared types, codes and constants of the LR parse engine.
`timescale 1ns / 1ps

package lrp_pkg;

    // Default table and stack sizes
    localparam int NUM_STATES_DEF       = 512;
    localparam int NUM_TERMINALS_DEF    = 512;
    localparam int NUM_NONTERMINALS_DEF = 256;
    localparam int NUM_PRODUCTIONS_DEF  = 512;
    localparam int STACK_DEPTH_DEF      = 512;
    localparam int MAX_RHS_DEF          = 127;

    // Action entry packing: kind in the low bits, target above
    localparam int ENT_TGT_LSB   = 2;
    localparam int ENT_KIND_MASK = 3;
    localparam int MAX_REDUCES   = 63;

    localparam int MODE_W    = 2;
    localparam int STATE_W   = 9;
    localparam int TERM_W    = 9;
    localparam int NT_W      = 8;
    localparam int PROD_W    = 9;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 7;
    localparam int EV_W      = 3;
    localparam int LEVEL_W   = 10;
    localparam int CNT_W     = 6;
    localparam int ACT_ENT_W = STATE_W + ENT_TGT_LSB;
    localparam int STK_AW    = 12;

    localparam logic [MODE_W-1:0] MODE_ACTION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GOTO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TOKEN  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd3;

    localparam logic [EV_W-1:0] EV_ACK    = 3'd0;
    localparam logic [EV_W-1:0] EV_REDUCE = 3'd1;
    localparam logic [EV_W-1:0] EV_SHIFT  = 3'd2;
    localparam logic [EV_W-1:0] EV_ACCEPT = 3'd3;
    localparam logic [EV_W-1:0] EV_ERROR  = 3'd4;
    localparam logic [EV_W-1:0] EV_FAULT  = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STATE_W-1:0] state_row;
        logic [TERM_W-1:0]  terminal;
        logic [NT_W-1:0]    nonterminal;
        logic [PROD_W-1:0]  production_id;
        logic [KIND_W-1:0]  action_kind;
        logic [STATE_W-1:0] entry_target;
        logic [LEN_W-1:0]   rhs_length;
    } t_in_item;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [PROD_W-1:0]  production_used;
        logic [NT_W-1:0]    lhs_symbol;
        logic [STATE_W-1:0] new_state;
        logic [LEVEL_W-1:0] stack_level;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic               act_we;
        logic               act_re;
        logic               goto_we;
        logic               goto_re;
        logic               prod_we;
        logic               prod_re;
        logic [STATE_W-1:0] row;
        logic [TERM_W-1:0]  term;
        logic [NT_W-1:0]    nt;
        logic [PROD_W-1:0]  pid;
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] target;
        logic [LEN_W-1:0]   len;
    } t_tbl_req;

    typedef struct packed {
        logic [KIND_W-1:0]  act_kind;
        logic [STATE_W-1:0] act_target;
        logic [STATE_W-1:0] goto_state;
        logic [NT_W-1:0]    prod_lhs;
        logic [LEN_W-1:0]   prod_len;
    } t_tbl_rsp;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [STK_AW-1:0]  waddr;
        logic [STK_AW-1:0]  raddr;
        logic [STATE_W-1:0] wdata;
    } t_stk_req;

endpackage

[rtl/core/lrp_tables.sv]
// Action, goto and production memories; range checks on writes, action/goto reads.
`timescale 1ns / 1ps

module lrp_tables #(
    parameter int NUM_STATES       = lrp_pkg::NUM_STATES_DEF,
    parameter int NUM_TERMINALS    = lrp_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_NONTERMINALS = lrp_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_PRODUCTIONS  = lrp_pkg::NUM_PRODUCTIONS_DEF,
    parameter int MAX_RHS          = lrp_pkg::MAX_RHS_DEF
) (
    input  logic              i_clk,
    input  lrp_pkg::t_tbl_req i_req,
    output lrp_pkg::t_tbl_rsp o_rsp
);

    localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
    localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
    localparam int AAW = $clog2(ACT_DEPTH);
    localparam int GAW = $clog2(GOTO_DEPTH);
    localparam int PAW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
    localparam int PE_W = lrp_pkg::NT_W + lrp_pkg::LEN_W;

    logic [lrp_pkg::ACT_ENT_W-1:0] act_mem  [ACT_DEPTH];
    logic [lrp_pkg::STATE_W-1:0]   goto_mem [GOTO_DEPTH];
    logic [PE_W-1:0]               prod_mem [NUM_PRODUCTIONS];

    logic [lrp_pkg::ACT_ENT_W-1:0] r_act_q;
    logic                          r_act_oor;
    logic [lrp_pkg::STATE_W-1:0]   r_goto_q;
    logic                          r_goto_oor;
    logic [PE_W-1:0]               r_prod_q;

    logic                          row_ok, term_ok, nt_ok, pid_ok, act_ok, goto_ok;
    logic [AAW-1:0]                act_addr;
    logic [GAW-1:0]                goto_addr;
    logic [PAW-1:0]                prod_addr;
    logic [lrp_pkg::ACT_ENT_W-1:0] act_entry;
    logic [lrp_pkg::LEN_W-1:0]     len_clamped;

    always_comb begin
        row_ok  = 32'(i_req.row) < NUM_STATES;
        term_ok = 32'(i_req.term) < NUM_TERMINALS;
        nt_ok   = 32'(i_req.nt) < NUM_NONTERMINALS;
        pid_ok  = 32'(i_req.pid) < NUM_PRODUCTIONS;
        act_ok  = row_ok && term_ok;
        goto_ok = row_ok && nt_ok;
        act_addr  = AAW'(32'(i_req.row) * NUM_TERMINALS + 32'(i_req.term));
        goto_addr = GAW'(32'(i_req.row) * NUM_NONTERMINALS + 32'(i_req.nt));
        prod_addr = PAW'(i_req.pid);
        act_entry = (lrp_pkg::ACT_ENT_W'(i_req.target) << lrp_pkg::ENT_TGT_LSB)
                  | (lrp_pkg::ACT_ENT_W'(i_req.kind)
                     & lrp_pkg::ACT_ENT_W'(lrp_pkg::ENT_KIND_MASK));
        len_clamped = (32'(i_req.len) > MAX_RHS) ? lrp_pkg::LEN_W'(MAX_RHS) : i_req.len;
    end

    // Writes outside the table are dropped
    always_ff @(posedge i_clk) begin
        if (i_req.act_we && act_ok) begin
            act_mem[act_addr] <= act_entry;
        end
        if (i_req.goto_we && goto_ok) begin
            goto_mem[goto_addr] <= i_req.target;
        end
        if (i_req.prod_we && pid_ok) begin
            prod_mem[prod_addr] <= {i_req.nt, len_clamped};
        end
    end

    // Read data holds until the next read of the same table
    always_ff @(posedge i_clk) begin
        if (i_req.act_re) begin
            r_act_oor <= !act_ok;
            if (act_ok) begin
                r_act_q <= act_mem[act_addr];
            end
        end
        if (i_req.goto_re) begin
            r_goto_oor <= !goto_ok;
            if (goto_ok) begin
                r_goto_q <= goto_mem[goto_addr];
            end
        end
        if (i_req.prod_re) begin
            r_prod_q <= prod_mem[prod_addr];
        end
    end

    always_comb begin
        o_rsp.act_kind   = r_act_oor ? lrp_pkg::KIND_ERROR
                         : lrp_pkg::KIND_W'(r_act_q
                                            & lrp_pkg::ACT_ENT_W'(lrp_pkg::ENT_KIND_MASK));
        o_rsp.act_target = r_act_oor ? '0
                         : lrp_pkg::STATE_W'(r_act_q >> lrp_pkg::ENT_TGT_LSB);
        o_rsp.goto_state = r_goto_oor ? '0 : r_goto_q;
        o_rsp.prod_lhs   = r_prod_q[PE_W-1:lrp_pkg::LEN_W];
        o_rsp.prod_len   = r_prod_q[lrp_pkg::LEN_W-1:0];
    end

endmodule

[rtl/core/lrp_stack.sv]
// State stack memory for the entries below the top of stack.
`timescale 1ns / 1ps

module lrp_stack #(
    parameter int STACK_DEPTH = lrp_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  lrp_pkg::t_stk_req           i_req,
    output logic [lrp_pkg::STATE_W-1:0] o_rdata
);

    localparam int SAW = $clog2(STACK_DEPTH);

    logic [lrp_pkg::STATE_W-1:0] stk_mem [STACK_DEPTH];
    logic [lrp_pkg::STATE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            stk_mem[i_req.waddr[SAW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= stk_mem[i_req.raddr[SAW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lr_shift_reduce_parse_engine.sv]
// Top level of the table-driven LR parse engine: sequencer and result register.
`timescale 1ns / 1ps

// Input items load the action, goto and production tables (modes 0 to 2) or
// carry one terminal token (mode 3). Results leave on the output channel, one
// per event; the final result of an item has last set.
// A table write is made when the item is taken; its ack leaves through the
// S_ACK state and the output register. A token's shift, accept or error
// decision is made in S_DEC from the action read of the current top; each
// reduction before it passes S_DEC, S_PROD, S_STK and S_GOTO for the
// production read, stack read, goto read and chained action read. The next
// item is taken once the sequencer is back in idle, after the last is done.
// The top of stack sits in a register; the entries below it live in the stack
// memory. Reset leaves one state 0 on the stack and needs no clearing pass;
// table contents are undefined until written.
// While the receiver stalls, the current result is held in the output register
// and the sequencer waits before producing the next one; an input item can
// still be taken while the last result of the previous one waits.
module lr_shift_reduce_parse_engine #(
    parameter int NUM_STATES       = lrp_pkg::NUM_STATES_DEF,
    parameter int NUM_TERMINALS    = lrp_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_NONTERMINALS = lrp_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_PRODUCTIONS  = lrp_pkg::NUM_PRODUCTIONS_DEF,
    parameter int STACK_DEPTH      = lrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_RHS          = lrp_pkg::MAX_RHS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lrp_pkg::t_out_item o_out_data
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_DEC,
        S_PROD,
        S_STK,
        S_GOTO
    } t_state;

    t_state                       r_state, n_state;
    logic [lrp_pkg::STATE_W-1:0]  r_top, n_top;
    logic [SPW-1:0]               r_sp, n_sp;
    logic [SPW-1:0]               r_pop, n_pop;
    logic [lrp_pkg::TERM_W-1:0]   r_term, n_term;
    logic [lrp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [lrp_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic [lrp_pkg::NT_W-1:0]     r_lhs, n_lhs;
    logic                         r_zlen, n_zlen;
    logic [lrp_pkg::STATE_W-1:0]  r_base, n_base;
    logic                         r_o_valid, n_o_valid;
    lrp_pkg::t_out_item           r_o_data, n_o_data;

    lrp_pkg::t_tbl_req            tbl_req;
    lrp_pkg::t_tbl_rsp            tbl_rsp;
    lrp_pkg::t_stk_req            stk_req;
    logic [lrp_pkg::STATE_W-1:0]  stk_rdata;

    logic                         out_free;
    logic                         emit;
    logic                         fin_req;
    logic [lrp_pkg::EV_W-1:0]     fin_ev;
    logic [SPW-1:0]               sp_pop;
    logic [lrp_pkg::STATE_W-1:0]  base;

    lrp_tables #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .NUM_PRODUCTIONS  (NUM_PRODUCTIONS),
        .MAX_RHS          (MAX_RHS)
    ) u_tables (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_rsp (tbl_rsp)
    );

    lrp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    assign out_free    = !r_o_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    always_comb begin
        n_state  = r_state;
        n_top    = r_top;
        n_sp     = r_sp;
        n_pop    = r_pop;
        n_term   = r_term;
        n_cnt    = r_cnt;
        n_prod   = r_prod;
        n_lhs    = r_lhs;
        n_zlen   = r_zlen;
        n_base   = r_base;
        n_o_data = r_o_data;
        tbl_req  = '0;
        stk_req  = '0;
        emit     = 1'b0;
        fin_req  = 1'b0;
        fin_ev   = lrp_pkg::EV_ERROR;
        sp_pop   = r_sp - SPW'(tbl_rsp.prod_len);
        base     = r_zlen ? r_top : stk_rdata;

        case (r_state)
            S_IDLE: begin
                tbl_req.row    = i_in_data.state_row;
                tbl_req.term   = i_in_data.terminal;
                tbl_req.nt     = i_in_data.nonterminal;
                tbl_req.pid    = i_in_data.production_id;
                tbl_req.kind   = i_in_data.action_kind;
                tbl_req.target = i_in_data.entry_target;
                tbl_req.len    = i_in_data.rhs_length;
                if (i_in_valid) begin
                    n_term = i_in_data.terminal;
                    n_cnt  = '0;
                    case (i_in_data.mode)
                        lrp_pkg::MODE_ACTION: tbl_req.act_we  = 1'b1;
                        lrp_pkg::MODE_GOTO:   tbl_req.goto_we = 1'b1;
                        lrp_pkg::MODE_PROD:   tbl_req.prod_we = 1'b1;
                        default: begin
                            // token: look up action of the current top
                            tbl_req.act_re = 1'b1;
                            tbl_req.row    = r_top;
                        end
                    endcase
                    n_state = (i_in_data.mode == lrp_pkg::MODE_TOKEN) ? S_DEC : S_ACK;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    emit     = 1'b1;
                    n_o_data = '{event_res:       lrp_pkg::EV_ACK,
                                 production_used: '0,
                                 lhs_symbol:      '0,
                                 new_state:       r_top,
                                 stack_level:     lrp_pkg::LEVEL_W'(r_sp),
                                 last:            1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_DEC: begin
                case (tbl_rsp.act_kind)
                    lrp_pkg::KIND_REDUCE: begin
                        if (32'(tbl_rsp.act_target) >= NUM_PRODUCTIONS) begin
                            fin_req = 1'b1;
                            fin_ev  = lrp_pkg::EV_ERROR;
                        end else if (r_cnt >= lrp_pkg::CNT_W'(lrp_pkg::MAX_REDUCES)) begin
                            fin_req = 1'b1;
                            fin_ev  = lrp_pkg::EV_FAULT;
                        end else begin
                            tbl_req.prod_re = 1'b1;
                            tbl_req.pid     = tbl_rsp.act_target;
                            n_prod          = tbl_rsp.act_target;
                            n_state         = S_PROD;
                        end
                    end
                    lrp_pkg::KIND_SHIFT: begin
                        if (32'(r_sp) >= STACK_DEPTH) begin
                            fin_req = 1'b1;
                            fin_ev  = lrp_pkg::EV_FAULT;
                        end else if (out_free) begin
                            // push: old top goes to memory, target becomes top
                            stk_req.we    = 1'b1;
                            stk_req.waddr = lrp_pkg::STK_AW'(r_sp - SPW'(1));
                            stk_req.wdata = r_top;
                            n_top         = tbl_rsp.act_target;
                            n_sp          = r_sp + SPW'(1);
                            emit          = 1'b1;
                            n_o_data = '{event_res:       lrp_pkg::EV_SHIFT,
                                         production_used: '0,
                                         lhs_symbol:      '0,
                                         new_state:       tbl_rsp.act_target,
                                         stack_level:     lrp_pkg::LEVEL_W'(r_sp + SPW'(1)),
                                         last:            1'b1};
                            n_state  = S_IDLE;
                        end
                    end
                    lrp_pkg::KIND_ACCEPT: begin
                        fin_req = 1'b1;
                        fin_ev  = lrp_pkg::EV_ACCEPT;
                    end
                    default: begin
                        fin_req = 1'b1;
                        fin_ev  = lrp_pkg::EV_ERROR;
                    end
                endcase
            end
            S_PROD: begin
                if (32'(tbl_rsp.prod_len) >= 32'(r_sp)) begin
                    fin_req = 1'b1;
                    fin_ev  = lrp_pkg::EV_FAULT;
                end else if (32'(r_sp) - 32'(tbl_rsp.prod_len) >= STACK_DEPTH) begin
                    fin_req = 1'b1;
                    fin_ev  = lrp_pkg::EV_FAULT;
                end else begin
                    n_pop  = sp_pop;
                    n_lhs  = tbl_rsp.prod_lhs;
                    n_zlen = (tbl_rsp.prod_len == '0);
                    // fetch the state uncovered by the pop
                    if (tbl_rsp.prod_len != '0) begin
                        stk_req.re    = 1'b1;
                        stk_req.raddr = lrp_pkg::STK_AW'(sp_pop - SPW'(1));
                    end
                    n_state = S_STK;
                end
            end
            S_STK: begin
                tbl_req.goto_re = 1'b1;
                tbl_req.row     = base;
                tbl_req.nt      = r_lhs;
                n_base          = base;
                n_state         = S_GOTO;
            end
            S_GOTO: begin
                if (out_free) begin
                    stk_req.we    = 1'b1;
                    stk_req.waddr = lrp_pkg::STK_AW'(r_pop - SPW'(1));
                    stk_req.wdata = r_base;
                    n_top         = tbl_rsp.goto_state;
                    n_sp          = r_pop + SPW'(1);
                    n_cnt         = r_cnt + lrp_pkg::CNT_W'(1);
                    emit          = 1'b1;
                    n_o_data = '{event_res:       lrp_pkg::EV_REDUCE,
                                 production_used: r_prod,
                                 lhs_symbol:      r_lhs,
                                 new_state:       tbl_rsp.goto_state,
                                 stack_level:     lrp_pkg::LEVEL_W'(r_pop + SPW'(1)),
                                 last:            1'b0};
                    // chain: look up the action for the same token on the new top
                    tbl_req.act_re = 1'b1;
                    tbl_req.row    = tbl_rsp.goto_state;
                    tbl_req.term   = r_term;
                    n_state        = S_DEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // accept, error and fault drop the stack back to the single state 0
        if (fin_req && out_free) begin
            emit     = 1'b1;
            n_o_data = '{event_res:       fin_ev,
                         production_used: '0,
                         lhs_symbol:      '0,
                         new_state:       '0,
                         stack_level:     lrp_pkg::LEVEL_W'(1),
                         last:            1'b1};
            n_top    = '0;
            n_sp     = SPW'(1);
            n_state  = S_IDLE;
        end

        n_o_valid = emit || (r_o_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_sp      <= SPW'(1);
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_sp      <= n_sp;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_pop    <= n_pop;
        r_term   <= n_term;
        r_prod   <= n_prod;
        r_lhs    <= n_lhs;
        r_zlen   <= n_zlen;
        r_base   <= n_base;
        r_o_data <= n_o_data;
    end

endmodule
